// ===== hdl/gsmis_pkg.sv =====
// shared types, constants and helper functions for the grid strip
// independent-sum core; used by every module in hdl/
`default_nettype none

package gsmis_pkg;

	localparam int CellW      = 32;
	localparam int PairW      = CellW + 1;
	localparam int SumW       = 51;
	localparam int RowN       = 4;
	localparam int PatN       = 8;
	localparam int PatIdxW    = 3;
	localparam int QueueDepth = 2;

	localparam logic signed [SumW-1:0]  SumMax  = {1'b0, {(SumW-1){1'b1}}};
	localparam logic signed [CellW-1:0] CellMin = {1'b1, {(CellW-1){1'b0}}};

	typedef logic [PatIdxW-1:0] pat_idx_t;
	typedef logic [RowN-1:0]    row_mask_t;

	// one column as handed from the front to the back
	typedef struct packed {
		logic [PatN-1:0][PairW-1:0] pat_sum;
		logic [CellW-1:0]           largest;
		logic                       last_col;
	} col_entry_t;

	// row patterns with no two vertically adjacent cells, bit 0 is row one
	function automatic row_mask_t pat_mask(input pat_idx_t idx);
		row_mask_t m;
		unique case (idx)
			3'd0:    m = 4'b0000;
			3'd1:    m = 4'b0001;
			3'd2:    m = 4'b0010;
			3'd3:    m = 4'b0100;
			3'd4:    m = 4'b0101;
			3'd5:    m = 4'b1000;
			3'd6:    m = 4'b1001;
			3'd7:    m = 4'b1010;
			default: m = 4'b0000;
		endcase
		return m;
	endfunction

	function automatic logic pat_compat(input pat_idx_t a, input pat_idx_t b);
		return (pat_mask(a) & pat_mask(b)) == '0;
	endfunction

	function automatic logic [SumW-1:0] smax(input logic [SumW-1:0] a,
			input logic [SumW-1:0] b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

	// three-level compare tree over the eight pattern values
	function automatic logic [SumW-1:0] pat_max8(input logic [PatN-1:0][SumW-1:0] v);
		logic [SumW-1:0] a0, a1, a2, a3, b0, b1;
		a0 = smax(v[0], v[1]);
		a1 = smax(v[2], v[3]);
		a2 = smax(v[4], v[5]);
		a3 = smax(v[6], v[7]);
		b0 = smax(a0, a1);
		b1 = smax(a2, a3);
		return smax(b0, b1);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/gsmis_front.sv =====
// front end: takes a column, forms the per-pattern cell sums and the running
// largest cell, and pushes the result into the column queue; uses gsmis_pkg
`default_nettype none

module gsmis_front (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   col_valid,
	output logic                                  col_ready,
	input  wire signed [gsmis_pkg::CellW-1:0]     cell_row1,
	input  wire signed [gsmis_pkg::CellW-1:0]     cell_row2,
	input  wire signed [gsmis_pkg::CellW-1:0]     cell_row3,
	input  wire signed [gsmis_pkg::CellW-1:0]     cell_row4,
	input  wire                                   last_column,
	output logic                                  push,
	output gsmis_pkg::col_entry_t                 push_data,
	input  wire                                   q_full
);
	import gsmis_pkg::*;

	logic signed [CellW-1:0] largest_q;
	logic signed [CellW-1:0] cells [RowN];
	logic signed [CellW-1:0] mx_a, mx_b, col_max, new_largest;
	logic signed [PairW-1:0] acc;
	row_mask_t               m;

	assign cells[0] = cell_row1;
	assign cells[1] = cell_row2;
	assign cells[2] = cell_row3;
	assign cells[3] = cell_row4;

	assign col_ready = !q_full;
	assign push      = col_valid && col_ready;

	always_comb begin
		mx_a        = (cells[0] > cells[1]) ? cells[0] : cells[1];
		mx_b        = (cells[2] > cells[3]) ? cells[2] : cells[3];
		col_max     = (mx_a > mx_b) ? mx_a : mx_b;
		new_largest = (col_max > largest_q) ? col_max : largest_q;
	end

	// at most two rows are set in any pattern, so the sum fits one extra bit
	always_comb begin
		acc = '0;
		m   = '0;
		for (int x = 0; x < PatN; x++) begin
			m   = pat_mask(pat_idx_t'(x));
			acc = '0;
			for (int r = 0; r < RowN; r++) begin
				if (m[r]) begin
					acc = acc + PairW'(cells[r]);
				end
			end
			push_data.pat_sum[x] = acc;
		end
		push_data.largest  = new_largest;
		push_data.last_col = last_column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= CellMin;
		end else if (push) begin
			largest_q <= last_column ? CellMin : new_largest;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/gsmis_queue.sv =====
// short register queue between front and back ends; uses gsmis_pkg for the
// entry type
`default_nettype none

module gsmis_queue #(
	parameter int DEPTH = gsmis_pkg::QueueDepth
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  gsmis_pkg::col_entry_t  push_data,
	output logic                   full,
	input  wire                    pop,
	output gsmis_pkg::col_entry_t  pop_data,
	output logic                   empty
);
	import gsmis_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	col_entry_t        mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = count_q == CntW'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue holds more entries than its depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== hdl/gsmis_back.sv =====
// back end: per-column pattern recurrence, grid restart on the last column
// and the result register with its final selection; uses gsmis_pkg
`default_nettype none

module gsmis_back (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  gsmis_pkg::col_entry_t               entry,
	input  wire                                 q_empty,
	output logic                                pop,
	output logic                                res_valid,
	input  wire                                 res_ready,
	output logic signed [gsmis_pkg::SumW-1:0]   best_sum
);
	import gsmis_pkg::*;

	logic [PatN-1:0][SumW-1:0] pb_q;
	logic                      first_q;
	logic [PatN-1:0][SumW-1:0] res_pat_q;
	logic signed [CellW-1:0]   res_large_q;
	logic                      res_valid_q;

	logic [PatN-1:0][SumW-1:0] cand, sel, nxt;
	logic [SumW-1:0]           pred, res_max;
	logic signed [SumW:0]      wide;
	logic                      res_free;

	assign res_free  = !res_valid_q || res_ready;
	assign pop       = !q_empty && (!entry.last_col || res_free);
	assign res_valid = res_valid_q;

	// predecessors only count when positive, and not at all on a first column
	always_comb begin
		for (int k = 0; k < PatN; k++) begin
			cand[k] = (!first_q && $signed(pb_q[k]) > 0) ? pb_q[k] : '0;
		end
	end

	always_comb begin
		sel  = '0;
		pred = '0;
		wide = '0;
		for (int x = 0; x < PatN; x++) begin
			for (int k = 0; k < PatN; k++) begin
				sel[k] = pat_compat(pat_idx_t'(x), pat_idx_t'(k)) ? cand[k] : '0;
			end
			pred = pat_max8(sel);
			wide = (SumW + 1)'($signed(entry.pat_sum[x])) + $signed({1'b0, pred});
			// saturate at the top of the sum range
			nxt[x] = (wide > $signed({1'b0, SumMax})) ? SumMax : wide[SumW-1:0];
		end
	end

	always_comb begin
		res_max = pat_max8(res_pat_q);
		if (res_large_q <= 0) begin
			best_sum = SumW'(res_large_q);
		end else begin
			best_sum = $signed(res_max);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q    <= '0;
			first_q <= 1'b1;
		end else if (pop) begin
			if (entry.last_col) begin
				pb_q    <= '0;
				first_q <= 1'b1;
			end else begin
				pb_q    <= nxt;
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && entry.last_col) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && entry.last_col) begin
			res_pat_q   <= nxt;
			res_large_q <= entry.largest;
		end
	end

	a_restart_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && entry.last_col |=> first_q && res_valid_q)
		else $error("grid did not restart or raise a result after its last column");
	a_carry_on_mid: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !entry.last_col |=> !first_q)
		else $error("first column flag still set after a mid-grid column");
	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> $signed(pb_q[0]) <= SumMax)
		else $error("pattern sum above saturation limit");
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !(pop && entry.last_col))
		else $error("result overwritten while still waiting");

endmodule

`default_nettype wire

// ===== hdl/grid_strip_max_independent_sum_core.sv =====
// Maximum-weight independent cell set over a four-row grid strip, fed one column
// per transaction on col_*, with one best_sum transaction on res_* after each
// column marked last_column. Sustained rate is one column per clock cycle while no
// last column waits on a pending result: the back end updates all eight row-pattern
// sums for a column together, and that pattern recurrence sets the throughput. The
// front end is combinational and each accepted column is written into the queue
// (QUEUE_DEPTH entries deep), from which the back end takes it; res_valid is
// registered and rises at the edge at which the last column leaves the queue. While
// a result waits, the back end keeps taking non-last columns of the next grid and
// only a second last column waits. If no cell of the grid is positive, best_sum is
// the largest cell. Sums saturate at the top of the 51-bit range.
`default_nettype none

module grid_strip_max_independent_sum_core #(
	parameter int QUEUE_DEPTH = gsmis_pkg::QueueDepth
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 col_valid,
	output logic                                col_ready,
	input  wire signed [gsmis_pkg::CellW-1:0]   cell_row1,
	input  wire signed [gsmis_pkg::CellW-1:0]   cell_row2,
	input  wire signed [gsmis_pkg::CellW-1:0]   cell_row3,
	input  wire signed [gsmis_pkg::CellW-1:0]   cell_row4,
	input  wire                                 last_column,
	output logic                                res_valid,
	input  wire                                 res_ready,
	output logic signed [gsmis_pkg::SumW-1:0]   best_sum
);
	import gsmis_pkg::*;

	col_entry_t push_data, pop_data;
	logic       push, pop, q_full, q_empty;

	gsmis_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_ready   (col_ready),
		.cell_row1   (cell_row1),
		.cell_row2   (cell_row2),
		.cell_row3   (cell_row3),
		.cell_row4   (cell_row4),
		.last_column (last_column),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	gsmis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	gsmis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (pop_data),
		.q_empty   (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.best_sum  (best_sum)
	);

endmodule

`default_nettype wire

// ===== bench/grid_strip_sum_checker.sv =====
// checker for the grid strip independent-sum core: watches both channels,
// predicts best_sum for every grid and compares it with each result transaction
// depends on gsmis_pkg for widths and limits
`timescale 1ns / 1ps

module grid_strip_sum_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               col_valid,
	input  wire                               col_ready,
	input  wire signed [gsmis_pkg::CellW-1:0] cell_row1,
	input  wire signed [gsmis_pkg::CellW-1:0] cell_row2,
	input  wire signed [gsmis_pkg::CellW-1:0] cell_row3,
	input  wire signed [gsmis_pkg::CellW-1:0] cell_row4,
	input  wire                               last_column,
	input  wire                               res_valid,
	input  wire                               res_ready,
	input  wire signed [gsmis_pkg::SumW-1:0]  best_sum,
	output int unsigned                       mismatches,
	output int unsigned                       sums_awaited
);
	import gsmis_pkg::*;

	// rows taken by each pattern, bit 0 is row one
	localparam logic [RowN-1:0] RowSets [PatN] = '{
		4'b0000, 4'b0001, 4'b0010, 4'b0100, 4'b0101, 4'b1000, 4'b1001, 4'b1010
	};
	localparam int ShownLimit = 10;

	logic signed [SumW-1:0]  run_best [PatN];
	logic signed [CellW-1:0] peak_cell;
	logic                    grid_open;
	logic signed [SumW-1:0]  grid_sums [$];
	logic signed [SumW-1:0]  want;
	int unsigned             shown;

	task automatic clear_grid();
		for (int p = 0; p < PatN; p++)
			run_best[p] = '0;
		peak_cell = CellMin;
		grid_open = 1'b0;
	endtask

	task automatic take_column(input logic signed [CellW-1:0] r1, r2, r3, r4,
			input logic last);
		logic signed [CellW-1:0] c [RowN];
		logic signed [SumW-1:0]  upd [PatN];
		logic signed [SumW-1:0]  grid_best;
		longint                  acc;
		longint                  link;
		c = '{r1, r2, r3, r4};
		for (int r = 0; r < RowN; r++)
			if (c[r] > peak_cell)
				peak_cell = c[r];
		for (int p = 0; p < PatN; p++) begin
			acc = 0;
			link = 0;
			for (int r = 0; r < RowN; r++)
				if (RowSets[p][r])
					acc += c[r];
			// on the first column of a grid every predecessor counts as zero
			if (grid_open)
				for (int q = 0; q < PatN; q++)
					if ((RowSets[p] & RowSets[q]) == '0 && run_best[q] > link)
						link = run_best[q];
			acc += link;
			if (acc > SumMax)
				acc = SumMax;
			upd[p] = acc[SumW-1:0];
		end
		run_best = upd;
		grid_open = 1'b1;
		if (last) begin
			grid_best = run_best[0];
			for (int p = 1; p < PatN; p++)
				if (run_best[p] > grid_best)
					grid_best = run_best[p];
			// nothing positive: at least one cell must still be picked
			if (peak_cell <= 0)
				grid_best = peak_cell;
			grid_sums.push_back(grid_best);
			clear_grid();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_grid();
			grid_sums.delete();
		end else begin
			if (col_valid && col_ready)
				take_column(cell_row1, cell_row2, cell_row3, cell_row4, last_column);
			if (res_valid && res_ready) begin
				if (grid_sums.size() == 0) begin
					mismatches++;
					if (shown < ShownLimit) begin
						shown++;
						$display("unexpected result transaction: best_sum %0d", best_sum);
					end
				end else begin
					want = grid_sums.pop_front();
					if (best_sum !== want) begin
						mismatches++;
						if (shown < ShownLimit) begin
							shown++;
							$display("best_sum wrong: expected %0d, got %0d", want, best_sum);
						end
					end
				end
			end
		end
		sums_awaited = grid_sums.size();
	end

endmodule

// ===== bench/grid_strip_max_independent_sum_core_tb.sv =====
// top of the bench for grid_strip_max_independent_sum_core: drives columns and
// random back-pressure, and gives the verdict from grid_strip_sum_checker
// depends on gsmis_pkg and the core itself
`timescale 1ns / 1ps

module grid_strip_max_independent_sum_core_tb;
	import gsmis_pkg::*;

	localparam int HalfPeriod      = 10;
	localparam int ResetCycles     = 12;
	localparam int WatchdogLimit   = 4000;
	localparam int DrainCycles     = 8;
	localparam int RandomColumns   = 1400;
	localparam int PhaseCount      = 4;
	// one long grid of all-max cells for large pattern sums
	localparam int LongColumns     = 100;

	localparam logic signed [CellW-1:0] CellMax = {1'b0, {(CellW-1){1'b1}}};

	typedef enum int {
		MixFull,
		MixSmall,
		MixNegative,
		MixEdges,
		MixNearZero
	} cell_mix_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    col_valid   = 1'b0;
	logic signed [CellW-1:0] cell_row1   = '0;
	logic signed [CellW-1:0] cell_row2   = '0;
	logic signed [CellW-1:0] cell_row3   = '0;
	logic signed [CellW-1:0] cell_row4   = '0;
	logic                    last_column = 1'b0;
	logic                    res_ready   = 1'b0;
	logic                    col_ready;
	logic                    res_valid;
	logic signed [SumW-1:0]  best_sum;

	int unsigned mismatches;
	int unsigned sums_awaited;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned columns_sent   = 0;

	always #HalfPeriod clk = ~clk;

	grid_strip_max_independent_sum_core dut (
		.clk,
		.arst_n,
		.col_valid,
		.col_ready,
		.cell_row1,
		.cell_row2,
		.cell_row3,
		.cell_row4,
		.last_column,
		.res_valid,
		.res_ready,
		.best_sum
	);

	grid_strip_sum_checker sum_check (
		.clk,
		.arst_n,
		.col_valid,
		.col_ready,
		.cell_row1,
		.cell_row2,
		.cell_row3,
		.cell_row4,
		.last_column,
		.res_valid,
		.res_ready,
		.best_sum,
		.mismatches,
		.sums_awaited
	);

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ends the run if no transaction moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((col_valid && col_ready) || (res_valid && res_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WatchdogLimit) begin
					$display("grid_strip_max_independent_sum_core: mismatch");
					$finish;
				end
			end
		end
	end

	function automatic logic signed [CellW-1:0] draw_cell(input cell_mix_t mix);
		logic [CellW-1:0] w;
		w = $urandom;
		case (mix)
			MixSmall:    return int'($urandom_range(32)) - 16;
			MixNegative: begin
				if ($urandom_range(1))
					return -int'($urandom_range(1, 50));
				return {1'b1, w[CellW-2:0]};
			end
			MixEdges: begin
				case ($urandom_range(5))
					0:       return CellMax;
					1:       return CellMin;
					2:       return 0;
					3:       return 1;
					4:       return -1;
					default: return w;
				endcase
			end
			MixNearZero: return int'($urandom_range(3)) - 3;
			default:     return w;
		endcase
	endfunction

	// mostly short grids, now and then a long one
	function automatic int unsigned grid_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return $urandom_range(1, 6);
		else if (roll < 95)
			return $urandom_range(7, 30);
		return $urandom_range(31, 120);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_column(input logic signed [CellW-1:0] r1, r2, r3, r4,
			input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			col_valid <= 1'b0;
			@(negedge clk);
		end
		col_valid   <= 1'b1;
		cell_row1   <= r1;
		cell_row2   <= r2;
		cell_row3   <= r3;
		cell_row4   <= r4;
		last_column <= last;
		do
			@(posedge clk);
		while (!col_ready);
		@(negedge clk);
		columns_sent++;
	endtask

	task automatic send_grid(input int unsigned columns, input cell_mix_t mix);
		for (int unsigned k = 0; k < columns; k++)
			send_column(draw_cell(mix), draw_cell(mix), draw_cell(mix), draw_cell(mix),
				k == columns - 1);
	endtask

	initial begin
		int unsigned target;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-column grids: positive, all negative, all zero, extremes
		send_column(5, -3, 7, 1, 1'b1);
		send_column(-5, -2, -9, -100, 1'b1);
		send_column(0, 0, 0, 0, 1'b1);
		send_column(CellMax, CellMin, CellMax, CellMin, 1'b1);
		send_column(CellMin, CellMin, CellMin, CellMin, 1'b1);
		send_column(CellMax, CellMax, CellMax, CellMax, 1'b1);
		// short grids
		send_column(1, 2, 3, 4, 1'b0);
		send_column(4, 3, 2, 1, 1'b1);
		send_column(0, -1, -1, -1, 1'b0);
		send_column(-5, 0, -3, -1, 1'b1);
		send_column(-7, -7, -7, -7, 1'b0);
		send_column(-7, -7, -7, -7, 1'b0);
		send_column(-1, -8, -9, -2, 1'b1);
		send_column(-1, 9, -1, 9, 1'b0);
		send_column(9, -1, 9, -1, 1'b0);
		send_column(CellMin, 3, CellMin, 3, 1'b1);
		send_column(CellMax, CellMax, CellMax, CellMax, 1'b0);
		send_column(CellMin, CellMax, CellMin, CellMax, 1'b0);
		send_column(CellMax, CellMin, CellMin, CellMax, 1'b1);

		// one long grid of the largest cells
		for (int unsigned k = 0; k < LongColumns; k++)
			send_column(CellMax, CellMax, CellMax, CellMax, k == LongColumns - 1);
		send_column(3, 1, 4, 1, 1'b1);

		for (int ph = 0; ph < PhaseCount; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 64;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 64;
				end
				default: begin
					send_idle_pct  = 9;
					recv_stall_pct = 9;
				end
			endcase
			target = columns_sent + RandomColumns / PhaseCount;
			while (columns_sent < target)
				send_grid(grid_length(), cell_mix_t'($urandom_range(MixNearZero)));
		end

		col_valid <= 1'b0;
		while (sums_awaited != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (mismatches == 0 && sums_awaited == 0)
			$display("grid_strip_max_independent_sum_core: match");
		else
			$display("grid_strip_max_independent_sum_core: mismatch");
		$finish;
	end

endmodule
